// ----- hw/rtl/sha1h_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 hasher.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package sha1h_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned LenPos     = 56;

  typedef logic [31:0] word_t;

  // Initial chaining values; element 0 is H0.
  localparam logic [NumWords-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] RND_PH1  = 7'd20;
  localparam logic [6:0] RND_PH2  = 7'd40;
  localparam logic [6:0] RND_PH3  = 7'd60;
  localparam logic [6:0] RND_LAST = 7'(Rounds - 1);

  localparam logic [5:0] POS_LAST = 6'(BlockBytes - 1);
  localparam logic [5:0] POS_LEN  = 6'(LenPos);
  localparam logic [2:0] WORD_LAST = 3'(NumWords - 1);

  typedef struct packed {
    logic       byte_present;
    logic [7:0] message_byte;
    logic       end_of_message;
  } sha1h_in_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } sha1h_out_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    BSEL_MSG,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } sha1h_bsel_e;

  typedef struct packed {
    logic        wr_byte;
    sha1h_bsel_e sel;
    logic        count_up;
    logic        latch_len;
    logic        start;
    logic        round;
    logic        add;
    logic        out_adv;
  } sha1h_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_at_len;
    logic round_last;
    logic word_last;
  } sha1h_sts_t;

  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < RND_PH1) begin
      f = (b & c) | (~b & d);
    end else if (rnd < RND_PH2) begin
      f = b ^ c ^ d;
    end else if (rnd < RND_PH3) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(logic [6:0] rnd);
    word_t k;
    if (rnd < RND_PH1) begin
      k = K_0;
    end else if (rnd < RND_PH2) begin
      k = K_1;
    end else if (rnd < RND_PH3) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

endpackage

// ----- hw/rtl/sha1h_ctrl.sv -----
// Controller state machine of the SHA-1 hasher: request intake, padding,
// compression sequencing and digest delivery. Depends on sha1h_pkg.
module sha1h_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   byte_present_i,
  input  logic                   end_of_message_i,
  input  logic                   out_stall_i,
  input  sha1h_pkg::sha1h_sts_t  sts_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output sha1h_pkg::sha1h_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P80   = 3'd1;
  localparam logic [2:0] S_PZERO = 3'd2;
  localparam logic [2:0] S_PLEN  = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic       in_acc, out_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    cmd_o.sel = sha1h_pkg::BSEL_MSG;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_present_i) begin
            cmd_o.wr_byte  = 1'b1;
            cmd_o.sel      = sha1h_pkg::BSEL_MSG;
            cmd_o.count_up = 1'b1;
            if (sts_i.pos_last) begin
              cmd_o.start = 1'b1;
              state_d     = S_RND;
              ret_d       = end_of_message_i ? S_P80 : S_IDLE;
            end else if (end_of_message_i) begin
              state_d = S_P80;
            end
          end else if (end_of_message_i) begin
            state_d = S_P80;
          end
        end
      end
      S_P80: begin
        cmd_o.wr_byte   = 1'b1;
        cmd_o.sel       = sha1h_pkg::BSEL_PAD;
        cmd_o.latch_len = 1'b1;
        if (sts_i.pos_last) begin
          cmd_o.start = 1'b1;
          state_d     = S_RND;
          ret_d       = S_PZERO;
        end else begin
          state_d = S_PZERO;
        end
      end
      S_PZERO: begin
        if (sts_i.pos_at_len) begin
          state_d = S_PLEN;
        end else begin
          cmd_o.wr_byte = 1'b1;
          cmd_o.sel     = sha1h_pkg::BSEL_ZERO;
          if (sts_i.pos_last) begin
            cmd_o.start = 1'b1;
            state_d     = S_RND;
            ret_d       = S_PZERO;
          end
        end
      end
      S_PLEN: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.sel     = sha1h_pkg::BSEL_LEN;
        if (sts_i.pos_last) begin
          cmd_o.start = 1'b1;
          state_d     = S_RND;
          ret_d       = S_OUT;
        end
      end
      S_RND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ret_q;
      end
      S_OUT: begin
        if (out_acc) begin
          cmd_o.out_adv = 1'b1;
          if (sts_i.word_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

// ----- hw/rtl/sha1h_dp.sv -----
// Datapath of the SHA-1 hasher: block buffer and message schedule, round
// unit, chaining words, counters and digest output. Depends on sha1h_pkg.
module sha1h_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha1h_pkg::sha1h_cmd_t  cmd_i,
  input  logic [7:0]             message_byte_i,
  output sha1h_pkg::sha1h_sts_t  sts_o,
  output sha1h_pkg::sha1h_out_t  out_req_o
);

  // The block buffer doubles as the 16-word schedule window; word 0 sits at
  // the top and is the oldest.
  logic [511:0] blk_q, blk_d;
  logic [5:0]   pos_q, pos_d;
  logic [60:0]  count_q, count_d;
  logic [63:0]  len_q, len_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [2:0]   widx_q, widx_d;
  logic [sha1h_pkg::NumWords-1:0][31:0] h_q, h_d;
  logic [sha1h_pkg::NumWords-1:0][31:0] v_q, v_d;

  logic [7:0]        wbyte;
  sha1h_pkg::word_t  w_cur, w_x, w_next, t_sum;
  logic              clear;

  always_comb begin
    unique case (cmd_i.sel)
      sha1h_pkg::BSEL_MSG:  wbyte = message_byte_i;
      sha1h_pkg::BSEL_PAD:  wbyte = sha1h_pkg::PAD_BYTE;
      sha1h_pkg::BSEL_ZERO: wbyte = 8'h00;
      sha1h_pkg::BSEL_LEN:  wbyte = len_q[63:56];
      default:              wbyte = 8'h00;
    endcase
  end

  assign w_cur  = blk_q[511:480];
  assign w_x    = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign w_next = {w_x[30:0], w_x[31]};

  assign t_sum = {v_q[0][26:0], v_q[0][31:27]}
               + sha1h_pkg::round_f(rnd_q, v_q[1], v_q[2], v_q[3])
               + v_q[4] + sha1h_pkg::round_k(rnd_q) + w_cur;

  assign clear = cmd_i.out_adv && sts_o.word_last;

  always_comb begin
    blk_d   = blk_q;
    pos_d   = pos_q;
    count_d = count_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    h_d     = h_q;
    v_d     = v_q;
    if (cmd_i.wr_byte) begin
      blk_d = {blk_q[503:0], wbyte};
      pos_d = pos_q + 6'd1;
    end else if (cmd_i.round) begin
      blk_d = {blk_q[479:0], w_next};
    end
    if (cmd_i.count_up) begin
      count_d = count_q + 61'd1;
    end
    if (cmd_i.latch_len) begin
      len_d = {count_q, 3'b000};
    end else if (cmd_i.wr_byte && (cmd_i.sel == sha1h_pkg::BSEL_LEN)) begin
      len_d = {len_q[55:0], 8'h00};
    end
    if (cmd_i.start) begin
      v_d   = h_q;
      rnd_d = 7'd0;
    end else if (cmd_i.round) begin
      v_d[0] = t_sum;
      v_d[1] = v_q[0];
      v_d[2] = {v_q[1][1:0], v_q[1][31:2]};
      v_d[3] = v_q[2];
      v_d[4] = v_q[3];
      rnd_d  = rnd_q + 7'd1;
    end
    if (cmd_i.add) begin
      for (int i = 0; i < sha1h_pkg::NumWords; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end
    if (cmd_i.out_adv) begin
      widx_d = widx_q + 3'd1;
    end
    if (clear) begin
      h_d     = sha1h_pkg::H_INIT;
      count_d = '0;
      pos_d   = '0;
      widx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
      h_q     <= sha1h_pkg::H_INIT;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    len_q <= len_d;
    v_q   <= v_d;
  end

  assign sts_o.pos_last   = (pos_q == sha1h_pkg::POS_LAST);
  assign sts_o.pos_at_len = (pos_q == sha1h_pkg::POS_LEN);
  assign sts_o.round_last = (rnd_q == sha1h_pkg::RND_LAST);
  assign sts_o.word_last  = (widx_q == sha1h_pkg::WORD_LAST);

  assign out_req_o.word_index  = widx_q;
  assign out_req_o.digest_word = h_q[widx_q];
  assign out_req_o.last_word   = sts_o.word_last;

endmodule

// ----- hw/rtl/sha1_hasher_unit.sv -----
// Top level of the streaming SHA-1 hasher.
// Joins sha1h_ctrl and sha1h_dp; types and constants come from sha1h_pkg.

// The unit hashes a byte stream with SHA-1 and returns the 160-bit digest as
// five 32-bit requests on the output channel, word 0 (H0) first, with
// last_word set on the fifth. Each input request may carry one message byte,
// an end-of-message mark, both (the byte counts as part of the message), or
// neither (it is taken and has no effect). The 64th byte of every block
// starts an 80-round compression at one round per clock, then the result is
// folded into the chaining words; the single shared round unit sets the
// pace. At the end mark the unit inserts the 0x80 pad byte, zero fill and
// the 64-bit big-endian bit length one byte per cycle outside compressions
// and runs one or two more compressions, then offers the five digest words,
// one per cycle while the output is not stalled. Input is stalled throughout
// padding, compression and digest delivery. After the last word is taken the
// unit is back in its reset state, ready for the next message. No clearing
// pass is needed after reset.
module sha1_hasher_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha1h_pkg::sha1h_in_t   in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha1h_pkg::sha1h_out_t  out_req_o
);

  // Command and status between the controller and the datapath.
  sha1h_pkg::sha1h_cmd_t cmd;
  sha1h_pkg::sha1h_sts_t sts;

  // The controller sequences intake, padding, rounds and delivery.
  sha1h_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .byte_present_i   (in_req_i.byte_present),
    .end_of_message_i (in_req_i.end_of_message),
    .out_stall_i      (out_stall_i),
    .sts_i            (sts),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .cmd_o            (cmd)
  );

  // The datapath holds the block buffer, round state and chaining words;
  // the digest word on offer comes straight from the chaining registers,
  // which hold still while it waits.
  sha1h_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_byte_i (in_req_i.message_byte),
    .sts_o          (sts),
    .out_req_o      (out_req_o)
  );

endmodule

// ----- hw/rtl/sha1h_checker.sv -----
// Port-level checks for the SHA-1 hasher, bound to sha1_hasher_unit.
// Depends on sha1h_pkg.
module sha1h_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sha1h_pkg::sha1h_out_t out_req_o
);

  // No input is taken while the digest is being delivered.
  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input not stalled during digest delivery");

  // A digest always starts at word 0.
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_req_o.word_index == 3'd0))
    else $error("digest does not start at word 0");

  // Words follow in order without gaps.
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_req_o.last_word) |=>
      (out_valid_o && (out_req_o.word_index == $past(out_req_o.word_index) + 3'd1)))
    else $error("digest words out of order");

  // The last word is word 4 and ends the digest.
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_req_o.last_word) |=>
      (!out_valid_o && ($past(out_req_o.word_index) == 3'd4)))
    else $error("digest does not end after word 4");

  // A stalled output request holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_req_o)))
    else $error("stalled output request changed");

endmodule

bind sha1_hasher_unit sha1h_checker u_sha1h_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

// ----- test/sha1_hasher_unit_test.sv -----
// Self-checking testbench for sha1_hasher_unit: directed table, then random messages.
// Expected digests come from a behavioural SHA-1 model in this file or known digests in the table.
// Depends on sha1h_pkg and the sha1_hasher_unit RTL.
`timescale 1ns / 1ps

module sha1_hasher_unit_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 250;
  localparam int NUM_ROWS     = 14;
  localparam int RANDOM_ITEMS = 86;
  localparam int MIN_MESSAGES = 4;

  // Well-known digests of the empty message and of "abc".
  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic                 has_known;
    logic [159:0]         known_digest;
    sha1h_pkg::sha1h_in_t req;
  } stim_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  sha1h_pkg::sha1h_in_t  in_req_i    = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  sha1h_pkg::sha1h_out_t out_req_o;

  // Model state: chaining words, block buffer and running byte count.
  sha1h_pkg::word_t chain_h [sha1h_pkg::NumWords];
  logic [7:0]       blk [sha1h_pkg::BlockBytes];
  logic [60:0]      msg_len;
  logic [159:0]     digest_bits;

  sha1h_pkg::sha1h_out_t digest_q [$];
  stim_row_t             stim_table [NUM_ROWS];

  int          error_count   = 0;
  int          cycle_count   = 0;
  int          burst_left    = 0;
  int          random_items  = 0;
  int          message_count = 0;
  bit          hold_armed    = 1'b0;
  bit          hold_done     = 1'b0;
  int          hold_left     = 0;
  int          seg_left      = 0;
  stall_mode_e seg_mode      = STALL_NONE;

  sha1_hasher_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic sha1h_pkg::word_t rotl(sha1h_pkg::word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < sha1h_pkg::NumWords; i++) begin
      chain_h[i] = sha1h_pkg::H_INIT[i];
    end
    msg_len = '0;
  endfunction

  // One 80-round compression of the block buffer into the chaining words.
  function automatic void compress_block();
    sha1h_pkg::word_t w [16];
    sha1h_pkg::word_t a, b, c, d, e, f, k, t, x, wt;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < sha1h_pkg::Rounds; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
        wt = rotl(x, 1);
        w[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1h_pkg::K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1h_pkg::K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1h_pkg::K_2;
      end else begin
        f = b ^ c ^ d;
        k = sha1h_pkg::K_3;
      end
      t = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Takes one request into the model. Returns 1 when it closes a message,
  // with the digest left in digest_bits and the model back at its start.
  function automatic bit absorb_request(sha1h_pkg::sha1h_in_t req);
    logic [63:0] bit_len;
    int pos;
    int i;
    if (req.byte_present) begin
      pos = int'(msg_len[5:0]);
      blk[pos] = req.message_byte;
      msg_len = msg_len + 61'd1;
      if (pos == sha1h_pkg::BlockBytes - 1) compress_block();
    end
    if (!req.end_of_message) return 1'b0;
    bit_len = {msg_len, 3'b000};
    pos = int'(msg_len[5:0]);
    blk[pos] = sha1h_pkg::PAD_BYTE;
    pos++;
    // No room left for the length: fill, compress and start a fresh block.
    if (pos > sha1h_pkg::LenPos) begin
      while (pos < sha1h_pkg::BlockBytes) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < sha1h_pkg::LenPos) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) begin
      blk[sha1h_pkg::LenPos + i] = bit_len[63 - 8*i -: 8];
    end
    compress_block();
    digest_bits = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    restart_hash();
    return 1'b1;
  endfunction

  function automatic void queue_digest(logic [159:0] words);
    sha1h_pkg::sha1h_out_t e;
    int i;
    for (i = 0; i < sha1h_pkg::NumWords; i++) begin
      e.word_index  = 3'(i);
      e.digest_word = words[159 - 32*i -: 32];
      e.last_word   = (i == sha1h_pkg::NumWords - 1);
      digest_q.push_back(e);
    end
  endfunction

  function automatic stim_row_t mk_row(logic bp, logic [7:0] data, logic eom,
                                       logic known, logic [159:0] dig);
    stim_row_t row;
    row.req.byte_present   = bp;
    row.req.message_byte   = data;
    row.req.end_of_message = eom;
    row.has_known          = known;
    row.known_digest       = dig;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offers one request and holds it until taken. The model is updated at the
  // accepting edge, so expected words are queued long before the block can
  // deliver them. Bursts and gaps of the sender are handled here too.
  task automatic offer_request(input sha1h_pkg::sha1h_in_t req, input bit use_known,
                               input logic [159:0] known);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    if (absorb_request(req)) begin
      queue_digest(use_known ? known : digest_bits);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  // A random message of len bytes, with the occasional empty request mixed
  // in. The end mark either rides on the last byte or follows on its own.
  task automatic send_message(input int len);
    sha1h_pkg::sha1h_in_t req;
    bit fold_end;
    int i;
    fold_end = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        req.byte_present   = 1'b0;
        req.message_byte   = 8'($urandom_range(0, 255));
        req.end_of_message = 1'b0;
        offer_request(req, 1'b0, '0);
      end
      req.byte_present   = 1'b1;
      req.message_byte   = 8'($urandom_range(0, 255));
      req.end_of_message = fold_end && (i == len - 1);
      offer_request(req, 1'b0, '0);
      random_items++;
    end
    if (!fold_end) begin
      req.byte_present   = 1'b0;
      req.message_byte   = 8'($urandom_range(0, 255));
      req.end_of_message = 1'b1;
      offer_request(req, 1'b0, '0);
      random_items++;
    end
    message_count++;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 7);
    // Lengths around the padding and block boundaries now and then.
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 55;
        1: return 56;
        2: return 63;
        3: return 64;
        default: return 65;
      endcase
    end
    return $urandom_range(0, 20);
  endfunction

  // Receiver: stretches of no stall, random stall and periodic stall. Once
  // armed, the first digest word it sees is held off for a long stretch so
  // that the block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_armed && !hold_done && out_valid_o) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = stall_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(1, 20);
        end
        seg_left--;
        case (seg_mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 1) == 1);
          default:        out_stall_i <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  // Each taken digest word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_req_o.digest_word, '0);
      end else begin
        if (out_req_o.word_index != digest_q[0].word_index) begin
          report_mismatch("word_index", 32'(out_req_o.word_index),
                          32'(digest_q[0].word_index));
        end
        if (out_req_o.digest_word != digest_q[0].digest_word) begin
          report_mismatch("digest_word", out_req_o.digest_word, digest_q[0].digest_word);
        end
        if (out_req_o.last_word != digest_q[0].last_word) begin
          report_mismatch("last_word", 32'(out_req_o.last_word),
                          32'(digest_q[0].last_word));
        end
        void'(digest_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int row;
    restart_hash();
    stim_table[0]  = mk_row(1'b0, 8'h00, 1'b1, 1'b1, DIGEST_EMPTY);
    stim_table[1]  = mk_row(1'b0, 8'hFF, 1'b0, 1'b0, '0);
    stim_table[2]  = mk_row(1'b1, 8'h61, 1'b0, 1'b0, '0);
    stim_table[3]  = mk_row(1'b1, 8'h62, 1'b0, 1'b0, '0);
    stim_table[4]  = mk_row(1'b1, 8'h63, 1'b1, 1'b1, DIGEST_ABC);
    stim_table[5]  = mk_row(1'b0, 8'h00, 1'b0, 1'b0, '0);
    stim_table[6]  = mk_row(1'b1, 8'h00, 1'b0, 1'b0, '0);
    stim_table[7]  = mk_row(1'b1, 8'hFF, 1'b0, 1'b0, '0);
    stim_table[8]  = mk_row(1'b0, 8'hA5, 1'b0, 1'b0, '0);
    stim_table[9]  = mk_row(1'b0, 8'h5A, 1'b1, 1'b0, '0);
    stim_table[10] = mk_row(1'b1, 8'hFF, 1'b1, 1'b0, '0);
    stim_table[11] = mk_row(1'b0, 8'hFF, 1'b1, 1'b1, DIGEST_EMPTY);
    stim_table[12] = mk_row(1'b1, 8'h80, 1'b0, 1'b0, '0);
    stim_table[13] = mk_row(1'b0, 8'h00, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < NUM_ROWS; row++) begin
      offer_request(stim_table[row].req, stim_table[row].has_known,
                    stim_table[row].known_digest);
    end

    hold_armed = 1'b1;
    while (random_items < RANDOM_ITEMS || message_count < MIN_MESSAGES) begin
      send_message(pick_length());
    end
    in_valid_i <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      report_mismatch("words still expected", 32'(digest_q.size()), '0);
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sha1h_pkg.sv
hw/rtl/sha1h_ctrl.sv
hw/rtl/sha1h_dp.sv
hw/rtl/sha1_hasher_unit.sv
hw/rtl/sha1h_checker.sv
test/sha1_hasher_unit_test.sv
